// ----- hdl/postfix_stack_evaluator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Shared check forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSEV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PSEV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/psev_pkg.sv -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared widths, token and status codes, and the control state type.
// ----------------------------------------------------------------------------
package psev_pkg;

   localparam int VALUE_W  = 32;
   localparam int DEPTH_W  = 7;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;
   localparam int STEP_W   = $clog2(VALUE_W);

   // token kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_OPER = 1'b1;

   // operator codes
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_UNDER   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OVER    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DIVZERO = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } psev_state_type;

endpackage

// ----- hdl/postfix_stack_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator core
// Push: never busy, result strobe the cycle after start; one item a cycle.
// Add, subtract, multiply: busy in ST_EXEC (stack read), result strobe right after ST_EXEC.
// Divide: busy through ST_EXEC and ST_DIV until the 32-step radix-2 divider is done.
// Errors (underflow, overflow, divide by zero) answer as fast as a push or add.
// Synchronous reset empties the stack; memory contents are left as they are.
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_core_defines.svh"

module postfix_stack_evaluator_core #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [psev_pkg::VALUE_W-1:0]   req_value,
   input  logic [psev_pkg::OP_W-1:0]             req_op,
   output logic                                  rsp_strobe,
   output logic signed [psev_pkg::VALUE_W-1:0]   rsp_top_value,
   output logic [psev_pkg::DEPTH_W-1:0]          rsp_depth,
   output logic [psev_pkg::STATUS_W-1:0]         rsp_status
);
   import psev_pkg::*;

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // The top of stack lives in top_ff; the memory holds the entries below it.
   // Entry i of the stack (i < sp-1) sits at stack_mem[i].
   logic [VALUE_W-1:0]   stack_mem [STACK_DEPTH];
   logic [VALUE_W-1:0]   rd_data_ff;

   psev_state_type       state_ff, state_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [VALUE_W-1:0]   top_ff, top_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic                 strobe_ff, strobe_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 accept;
   logic                 full;
   logic                 short_stack;
   logic [SP_W-1:0]      sp_m1;
   logic [SP_W-1:0]      sp_m2;
   logic                 mem_we;
   logic [VALUE_W-1:0]   left;
   logic [VALUE_W-1:0]   right;
   logic [VALUE_W-1:0]   mul_lo;
   logic                 div_start;
   logic                 div_done;
   logic [VALUE_W-1:0]   div_quot;

   assign accept      = start && (state_ff == ST_IDLE);
   assign full        = (sp_ff >= SP_W'(STACK_DEPTH));
   assign short_stack = (sp_ff < SP_W'(2));
   assign sp_m1       = sp_ff - SP_W'(1);
   assign sp_m2       = sp_ff - SP_W'(2);

   // left operand comes from memory (read issued at accept), right is the top
   assign left   = rd_data_ff;
   assign right  = top_ff;
   assign mul_lo = left * right;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_OPER) && !short_stack) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((op_ff == OP_DIV) && (right != '0)) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- datapath control ----------------
   always_comb begin
      sp_in     = sp_ff;
      top_in    = top_ff;
      op_in     = op_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      mem_we    = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_op;
               if (req_kind == KIND_PUSH) begin
                  strobe_in = 1'b1;
                  if (full) begin
                     status_in = STAT_OVER;
                  end else begin
                     // old top spills into memory, new value becomes top
                     mem_we    = (sp_ff != '0);
                     top_in    = $unsigned(req_value);
                     sp_in     = sp_ff + SP_W'(1);
                     status_in = STAT_OK;
                  end
               end else if (short_stack) begin
                  strobe_in = 1'b1;
                  status_in = STAT_UNDER;
               end
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ADD: begin
                  top_in    = left + right;
                  sp_in     = sp_m1;
                  strobe_in = 1'b1;
                  status_in = STAT_OK;
               end
               OP_SUB: begin
                  top_in    = left - right;
                  sp_in     = sp_m1;
                  strobe_in = 1'b1;
                  status_in = STAT_OK;
               end
               OP_MUL: begin
                  top_in    = mul_lo;
                  sp_in     = sp_m1;
                  strobe_in = 1'b1;
                  status_in = STAT_OK;
               end
               default: begin
                  // divide: zero divisor leaves both operands in place
                  if (right == '0) begin
                     strobe_in = 1'b1;
                     status_in = STAT_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               top_in    = div_quot;
               sp_in     = sp_m1;
               strobe_in = 1'b1;
               status_in = STAT_OK;
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sp_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sp_ff     <= sp_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      op_ff     <= op_in;
      status_ff <= status_in;
   end

   // ---------------- operand memory ----------------
   // Writes happen only at a push accept; a read is issued at every accept but
   // only an operator uses it, and an operator accept never writes: no bypass.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[sp_m1[ADDR_W-1:0]] <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= stack_mem[sp_m2[ADDR_W-1:0]];
      end
   end

   // ---------------- divider ----------------
   psev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (left),
      .divisor  (right),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------- result port ----------------
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_depth     = DEPTH_W'(sp_ff);
   assign rsp_top_value = (sp_ff == '0) ? '0 : $signed(top_ff);

   // ---------------- checks ----------------
   `PSEV_ASSERT_IMP(a_strobe_when_idle, clock, reset, strobe_ff, state_ff == ST_IDLE, "result strobe while busy")
   `PSEV_ASSERT_IMP(a_sp_bound, clock, reset, 1'b1, sp_ff <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
   `PSEV_ASSERT_NXT(a_divzero_keeps, clock, reset, (state_ff == ST_EXEC) && (op_ff == OP_DIV) && (top_ff == '0), strobe_ff && (status_ff == STAT_DIVZERO) && (sp_ff == $past(sp_ff)), "divide by zero changed stack")
   `PSEV_ASSERT_NXT(a_div_pops, clock, reset, (state_ff == ST_DIV) && div_done, strobe_ff && (sp_ff == $past(sp_m1)), "divide result did not pop")

endmodule

// ----- hdl/psev_div.sv -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator divider
// Radix-2 restoring divide on magnitudes, truncating toward zero.
// ----------------------------------------------------------------------------
module psev_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psev_pkg::VALUE_W-1:0]   dividend,
   input  logic [psev_pkg::VALUE_W-1:0]   divisor,
   output logic                           done,
   output logic [psev_pkg::VALUE_W-1:0]   quotient
);
   import psev_pkg::*;

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [VALUE_W:0]     rem_shift;
   logic [VALUE_W:0]     rem_diff;

   assign rem_shift = {rem_ff, quo_ff[VALUE_W-1]};
   assign rem_diff  = rem_shift - {1'b0, mag_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend[VALUE_W-1] ? (VALUE_W'(0) - dividend) : dividend;
         mag_in     = divisor[VALUE_W-1] ? (VALUE_W'(0) - divisor) : divisor;
         neg_in     = dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
      end else if (running_ff) begin
         // one quotient bit per cycle
         if (!rem_diff[VALUE_W]) begin
            rem_in = rem_diff[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (VALUE_W'(0) - quo_ff) : quo_ff;

endmodule

// ----- tb/postfix_stack_evaluator_checker.sv -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator result checker
// Watches the token and result channels, keeps its own copy of the operand
// stack, predicts the report for every accepted token and compares in order.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [psev_pkg::VALUE_W-1:0]   req_value,
   input  logic [psev_pkg::OP_W-1:0]             req_op,
   input  logic                                  rsp_strobe,
   input  logic signed [psev_pkg::VALUE_W-1:0]   rsp_top_value,
   input  logic [psev_pkg::DEPTH_W-1:0]          rsp_depth,
   input  logic [psev_pkg::STATUS_W-1:0]         rsp_status,
   output int                                    failures,
   output int                                    outstanding
);
   import psev_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0]  top_value;
      logic [DEPTH_W-1:0]  depth;
      logic [STATUS_W-1:0] status;
   } stack_report_type;

   logic [VALUE_W-1:0] shadow_stack [STACK_DEPTH];
   int unsigned        shadow_sp = 0;
   stack_report_type   expected_reports [$];

   // C-style quotient: truncates toward zero, most negative / -1 wraps
   function automatic logic [VALUE_W-1:0] trunc_quotient(input logic [VALUE_W-1:0] num,
                                                         input logic [VALUE_W-1:0] den);
      logic [VALUE_W-1:0] num_mag;
      logic [VALUE_W-1:0] den_mag;
      logic [VALUE_W-1:0] quo;
      num_mag = num[VALUE_W-1] ? -num : num;
      den_mag = den[VALUE_W-1] ? -den : den;
      quo     = num_mag / den_mag;
      return (num[VALUE_W-1] ^ den[VALUE_W-1]) ? -quo : quo;
   endfunction

   // applies one token to the shadow stack and returns the report it causes
   function automatic stack_report_type evaluate_token(input logic               kind,
                                                       input logic [VALUE_W-1:0] value,
                                                       input logic [OP_W-1:0]    op);
      stack_report_type    rep;
      logic [VALUE_W-1:0]  lhs;
      logic [VALUE_W-1:0]  rhs;
      logic [VALUE_W-1:0]  res;
      logic [STATUS_W-1:0] stat;
      stat = STAT_OK;
      res  = '0;
      if (kind == KIND_PUSH) begin
         if (shadow_sp >= STACK_DEPTH) begin
            stat = STAT_OVER;
         end else begin
            shadow_stack[shadow_sp] = value;
            shadow_sp++;
         end
      end else if (shadow_sp < 2) begin
         stat = STAT_UNDER;
      end else begin
         rhs = shadow_stack[shadow_sp-1];
         lhs = shadow_stack[shadow_sp-2];
         case (op)
            OP_ADD: begin
               res = lhs + rhs;
            end
            OP_SUB: begin
               res = lhs - rhs;
            end
            OP_MUL: begin
               res = lhs * rhs;
            end
            default: begin
               // divide
               if (rhs == '0) stat = STAT_DIVZERO;
               else res = trunc_quotient(lhs, rhs);
            end
         endcase
         // errors leave the stack as it was
         if (stat == STAT_OK) begin
            shadow_sp--;
            shadow_stack[shadow_sp-1] = res;
         end
      end
      rep.top_value = (shadow_sp > 0) ? shadow_stack[shadow_sp-1] : '0;
      rep.depth     = DEPTH_W'(shadow_sp);
      rep.status    = stat;
      return rep;
   endfunction

   always @(posedge clock) begin
      stack_report_type want;
      if (reset) begin
         shadow_sp = 0;
         expected_reports.delete();
      end else begin
         // compare first: a report never belongs to a token taken on the same edge
         if (rsp_strobe) begin
            if (expected_reports.size() == 0) begin
               $error("report with no token outstanding: top_value %0d depth %0d status %0d",
                      rsp_top_value, rsp_depth, rsp_status);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_top_value !== want.top_value) begin
                  $error("top_value: expected %0d, got %0d", $signed(want.top_value),
                         rsp_top_value);
                  failures++;
               end
               if (rsp_depth !== want.depth) begin
                  $error("depth: expected %0d, got %0d", want.depth, rsp_depth);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
            end
         end
         if (start && !busy)
            expected_reports.push_back(evaluate_token(req_kind, req_value, req_op));
      end
      outstanding = expected_reports.size();
   end

endmodule

// ----- tb/postfix_stack_evaluator_core_tb.sv -----
// ----------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Drives tokens through the command port: a short directed run over the
// operators and error cases, then random segments that fill, drain or hover
// around the middle of the stack. The checker predicts and compares reports.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core_tb;
   import psev_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 40;     // longer than a divide
   localparam int WAIT_LIMIT   = 5000;

   localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        start     = 1'b0;
   logic                        req_kind  = KIND_PUSH;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic [OP_W-1:0]             req_op    = OP_ADD;
   logic                        busy;
   logic                        rsp_strobe;
   logic signed [VALUE_W-1:0]   rsp_top_value;
   logic [DEPTH_W-1:0]          rsp_depth;
   logic [STATUS_W-1:0]         rsp_status;

   int failures;
   int outstanding;
   bit idle_enabled = 1'b1;

   always #1 clock = ~clock;

   postfix_stack_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_op       (req_op),
      .rsp_strobe   (rsp_strobe),
      .rsp_top_value(rsp_top_value),
      .rsp_depth    (rsp_depth),
      .rsp_status   (rsp_status)
   );

   postfix_stack_evaluator_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) stack_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_op       (req_op),
      .rsp_strobe   (rsp_strobe),
      .rsp_top_value(rsp_top_value),
      .rsp_depth    (rsp_depth),
      .rsp_status   (rsp_status),
      .failures     (failures),
      .outstanding  (outstanding)
   );

   // Hard stop for a run that never finishes.
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   // Offers one item and returns at the edge that takes it.
   // Start is only lowered inside an idle gap, so back-to-back items keep
   // start high without a same-step low/high pair. Busy is sampled at the
   // falling edge, where it is stable, to decide whether the next rising
   // edge takes the item.
   task automatic send_token(input logic               kind,
                             input logic [VALUE_W-1:0] value,
                             input logic [OP_W-1:0]    op);
      logic held;
      while (idle_enabled && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_op    <= op;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
   endtask

   // unused fields carry random bits so the block must ignore them
   task automatic push_operand(input logic [VALUE_W-1:0] value);
      send_token(KIND_PUSH, value, OP_W'($urandom));
   endtask

   task automatic apply_op(input logic [OP_W-1:0] op);
      send_token(KIND_OPER, $urandom, op);
   endtask

   // operand mix: small values make zero divisors and exact quotients
   // likely, extremes hit the wrap cases, the rest covers every bit
   function automatic logic [VALUE_W-1:0] pick_operand();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return $urandom_range(0, 32) - 16;
      if (pick < 55) begin
         case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            3:       return MOST_NEG;
            default: return MOST_POS;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int sent;
      int mode;
      int push_pct;
      int seg_len;
      int guard;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed tokens ----
      apply_op(OP_ADD);          // operator on empty stack: underflow
      push_operand(7);
      apply_op(OP_SUB);          // one entry only: underflow
      push_operand(-3);
      apply_op(OP_MUL);          // -21
      push_operand(0);
      apply_op(OP_DIV);          // divide by zero, both operands stay
      apply_op(OP_ADD);          // -21 + 0
      push_operand(4);
      apply_op(OP_DIV);          // -21 / 4 truncates to -5
      push_operand(MOST_NEG);
      push_operand(-1);
      apply_op(OP_DIV);          // most negative / -1 wraps to itself
      push_operand(MOST_POS);
      push_operand(MOST_POS);
      apply_op(OP_MUL);          // product wraps to 1
      push_operand(MOST_POS);
      apply_op(OP_ADD);          // sum wraps to most negative
      apply_op(OP_SUB);          // most negative - most negative = 0
      push_operand(MOST_NEG);
      push_operand(1);
      apply_op(OP_SUB);          // difference wraps to most positive
      push_operand(-7);
      apply_op(OP_DIV);          // positive / negative truncates toward zero

      // ---- random segments ----
      // Fill segments run into overflow, drain segments into underflow,
      // balanced ones keep a deep stack busy with random arithmetic.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode < 2)      push_pct = 92;
         else if (mode < 4) push_pct = 15;
         else               push_pct = 55;
         seg_len = $urandom_range(20, 120);
         for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
            // one long stretch with back-to-back items
            idle_enabled = !(sent >= 500 && sent < 800);
            if ($urandom_range(0, 99) < push_pct) push_operand(pick_operand());
            else apply_op(OP_W'($urandom_range(0, 3)));
            sent++;
         end
      end
      start <= 1'b0;

      // wait for every report, then watch a while for strays
      guard = 0;
      do begin
         @(negedge clock);
         guard++;
      end while (outstanding != 0 && guard < WAIT_LIMIT);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
